FILE: sv/lpcsf_pkg.sv
// Shared constants and types for the LPC synthesis filter.
package lpcsf_pkg;

  localparam int ORDER_DEF        = 10;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 16;

  localparam int SAMPLE_FRAC = 8;
  localparam int COEF_FRAC   = 12;
  localparam int OUT_WIDTH   = 16;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_FILTER = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

endpackage

FILE: sv/lpc_synthesis_filter_saturate_unit.sv
// Tenth-order all-pole synthesis filter with one shared multiply-accumulate unit.
// A filter beat passes through the multiply, drain, saturate and output load states in
// turn, with one multiply per tap; the input stalls meanwhile.
// The next beat is taken only once the result is loaded; a stalled result holds the load.
// Coefficient writes and clears give no result.
// Synchronous reset clears history, coefficients and the output valid.
module lpc_synthesis_filter_saturate_unit
  import lpcsf_pkg::*;
#(
  parameter int ORDER        = ORDER_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic [3:0]                     coef_index,
  input  logic signed [COEF_WIDTH-1:0]   coef_value,
  input  logic signed [SAMPLE_WIDTH-1:0] excitation,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [OUT_WIDTH-1:0]    speech_sample,
  output logic                           clipped
);

  localparam int IDX_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = SAMPLE_WIDTH + COEF_WIDTH + 5;
  localparam int T_W    = 34;
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
  localparam logic signed [T_W-1:0] T_HI = T_W'(32767 * (1 << SAMPLE_FRAC));
  localparam logic signed [T_W-1:0] T_LO = T_W'(-32768 * (1 << SAMPLE_FRAC));
  localparam logic signed [T_W-1:0] T_RND = T_W'((1 << SAMPLE_FRAC) - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_SAT,
    S_OUT
  } state_t;

  state_t                         state;
  logic [IDX_W-1:0]               k;
  logic signed [SAMPLE_WIDTH-1:0] history [ORDER];
  logic signed [COEF_WIDTH-1:0]   coefficients [ORDER];
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [SAMPLE_WIDTH-1:0] s;

  logic signed [ACC_W-1:0]        s_full;
  logic signed [SAMPLE_WIDTH-1:0] s_next;
  logic signed [T_W-1:0]          t;
  logic signed [T_W-1:0]          t_adj;
  logic signed [T_W-1:0]          t_div;
  logic signed [OUT_WIDTH-1:0]    sample_next;
  logic                           clip_next;
  logic                           accept;
  logic                           out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    s_full = acc >>> COEF_FRAC;
    if (s_full > SMAX) begin
      s_next = SAMPLE_WIDTH'(SMAX);
    end else if (s_full < SMIN) begin
      s_next = SAMPLE_WIDTH'(SMIN);
    end else begin
      s_next = SAMPLE_WIDTH'(s_full);
    end
  end

  always_comb begin
    t     = T_W'(s) <<< 1;
    t_adj = (t < 0) ? (t + T_RND) : t;
    t_div = t_adj >>> SAMPLE_FRAC;
    if (t > T_HI) begin
      sample_next = OUT_WIDTH'(32767);
      clip_next   = 1'b1;
    end else if (t < T_LO) begin
      sample_next = OUT_WIDTH'(-32768);
      clip_next   = 1'b1;
    end else begin
      sample_next = OUT_WIDTH'(t_div);
      clip_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coefficients[k] * history[k];
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        history[i]      <= '0;
        coefficients[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_WRITE: begin
                if ({1'b0, coef_index} < 5'(ORDER)) begin
                  coefficients[coef_index[IDX_W-1:0]] <= coef_value;
                end
              end
              ACT_FILTER: begin
                acc   <= ACC_W'(excitation) <<< COEF_FRAC;
                k     <= '0;
                state <= S_MAC;
              end
              ACT_CLEAR: begin
                for (int i = 0; i < ORDER; i++) begin
                  history[i] <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MAC: begin
          if (k != '0) begin
            acc <= acc - ACC_W'(prod);
          end
          if (k == IDX_W'(ORDER - 1)) begin
            state <= S_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DRAIN: begin
          acc   <= acc - ACC_W'(prod);
          state <= S_SAT;
        end
        S_SAT: begin
          s <= s_next;
          for (int i = ORDER - 1; i > 0; i--) begin
            history[i] <= history[i-1];
          end
          history[0] <= s_next;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            speech_sample <= sample_next;
            clipped       <= clip_next;
            out_valid     <= 1'b1;
            k             <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result beat raised outside output load");

  a_filter_starts_mac: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_FILTER) |=> (state == S_MAC && k == '0))
    else $error("filter beat did not start multiply sequence");

  a_tap_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (k <= IDX_W'(ORDER - 1)))
    else $error("tap counter out of range");

  a_no_beat_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(speech_sample) && $stable(clipped))
    else $error("pending result overwritten");

endmodule

FILE: sim/lpc_synthesis_filter_saturate_unit_tb.sv
// Self-checking testbench for the tenth-order LPC synthesis filter with output saturation.
module lpc_synthesis_filter_saturate_unit_tb;
  import lpcsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_BEATS = 400;

  typedef struct packed {
    logic [1:0]                         action;
    logic [3:0]                         coef_index;
    logic signed [COEF_WIDTH_DEF-1:0]   coef_value;
    logic signed [SAMPLE_WIDTH_DEF-1:0] excitation;
  } beat_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] sample;
    logic                        clip;
  } speech_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_WRITE;
  logic [3:0] coef_index = '0;
  logic signed [COEF_WIDTH_DEF-1:0] coef_value = '0;
  logic signed [SAMPLE_WIDTH_DEF-1:0] excitation = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_WIDTH-1:0] speech_sample;
  logic clipped;

  beat_t   pending_beats[$];
  speech_t expected_samples[$];

  logic signed [SAMPLE_WIDTH_DEF-1:0] hist_model[ORDER_DEF];
  logic signed [COEF_WIDTH_DEF-1:0]   coef_model[ORDER_DEF];

  logic in_taken = 1'b0;
  logic hold_off = 1'b0;
  logic pressure_go = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int counted_beats = 0;
  int filters_queued = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  lpc_synthesis_filter_saturate_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .excitation   (excitation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .speech_sample(speech_sample),
    .clipped      (clipped)
  );

  always #2 clk = ~clk;

  function automatic void filter_predict(beat_t b);
    longint  acc, s, t, smax, smin;
    speech_t r;
    smax = (longint'(1) <<< (SAMPLE_WIDTH_DEF - 1)) - 1;
    smin = -smax - 1;
    case (b.action)
      ACT_WRITE: begin
        if (b.coef_index < ORDER_DEF) coef_model[b.coef_index] = b.coef_value;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < ORDER_DEF; i++) hist_model[i] = '0;
      end
      ACT_FILTER: begin
        acc = longint'($signed(b.excitation)) <<< COEF_FRAC;
        for (int i = 0; i < ORDER_DEF; i++)
          acc -= longint'($signed(coef_model[i])) * longint'($signed(hist_model[i]));
        s = acc >>> COEF_FRAC;
        if (s > smax) s = smax;
        if (s < smin) s = smin;
        for (int i = ORDER_DEF - 1; i > 0; i--) hist_model[i] = hist_model[i-1];
        hist_model[0] = SAMPLE_WIDTH_DEF'(s);
        t = 2 * s;
        if (t > longint'(32767) * 256) begin
          r.sample = 16'sd32767;
          r.clip   = 1'b1;
        end else if (t < longint'(-32768) * 256) begin
          r.sample = -16'sd32768;
          r.clip   = 1'b1;
        end else begin
          r.sample = OUT_WIDTH'(t / 256);
          r.clip   = 1'b0;
        end
        expected_samples.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void push_op(logic [1:0] act, int idx, int arg);
    beat_t b;
    b.action     = act;
    b.coef_index = 4'(idx);
    b.coef_value = COEF_WIDTH_DEF'($urandom);
    b.excitation = SAMPLE_WIDTH_DEF'($urandom);
    if (act == ACT_WRITE) b.coef_value = COEF_WIDTH_DEF'(arg);
    if (act == ACT_FILTER) b.excitation = SAMPLE_WIDTH_DEF'(arg);
    pending_beats.push_back(b);
    if (act != ACT_UNUSED && !(act == ACT_WRITE && idx >= ORDER_DEF)) counted_beats++;
    if (act == ACT_FILTER) filters_queued++;
  endfunction

  function automatic int rand_excitation();
    case ($urandom_range(3))
      0: return int'($urandom) >>> 8;
      1: return int'($urandom_range(65535)) - 32768;
      2: return int'($urandom_range(2097151)) - 1048576;
      default: return $urandom_range(1) ? 8388607 : -8388608;
    endcase
  endfunction

  function automatic int rand_coef(int tap, int style);
    case (style)
      0: return int'($urandom_range(4095)) - 2048;
      1: return (int'($urandom_range(16383)) - 8192) >>> tap;
      default: return int'($urandom) >>> 16;
    endcase
  endfunction

  // drive input beats; hold until taken
  always @(negedge clk) begin
    beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      nxt = pending_beats.pop_front();
      in_valid   <= 1'b1;
      action     <= nxt.action;
      coef_index <= nxt.coef_index;
      coef_value <= nxt.coef_value;
      excitation <= nxt.excitation;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && (hold_off || $urandom_range(99) < recv_stall_pct);
  end

  // check results before predicting the beat taken at the same edge
  always @(posedge clk) begin
    beat_t   seen;
    speech_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: sample %0d clipped %0d", speech_sample, clipped);
        end else begin
          want = expected_samples.pop_front();
          if (speech_sample !== want.sample || clipped !== want.clip) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected sample %0d clipped %0d, got sample %0d clipped %0d",
                       results_checked, want.sample, want.clip, speech_sample, clipped);
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen.action     = action;
        seen.coef_index = coef_index;
        seen.coef_value = coef_value;
        seen.excitation = excitation;
        filter_predict(seen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (pressure_go);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    int target;
    int style;
    send_pcts = '{0, 66, 0, 25};
    recv_pcts = '{0, 0, 66, 25};
    for (int i = 0; i < ORDER_DEF; i++) begin
      hist_model[i] = '0;
      coef_model[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == 0) begin
        push_op(ACT_FILTER, 0, 0);
        push_op(ACT_FILTER, 15, 8388607);
        push_op(ACT_FILTER, 3, -8388608);
        push_op(ACT_FILTER, 7, 4194176);
        push_op(ACT_FILTER, 9, 4194177);
        push_op(ACT_FILTER, 1, -4194304);
        push_op(ACT_FILTER, 2, -4194305);
        push_op(ACT_FILTER, 4, -1);
        push_op(ACT_FILTER, 5, 127);
        push_op(ACT_FILTER, 6, -128);
        push_op(ACT_WRITE, 0, 32767);
        push_op(ACT_WRITE, 9, -32768);
        push_op(ACT_WRITE, 10, 1234);
        push_op(ACT_WRITE, 15, -1);
        push_op(ACT_FILTER, 0, 1000);
        push_op(ACT_FILTER, 8, -1000);
        push_op(ACT_FILTER, 11, 0);
        push_op(ACT_UNUSED, 12, $urandom);
        push_op(ACT_FILTER, 13, 0);
        push_op(ACT_CLEAR, 14, $urandom);
        push_op(ACT_FILTER, 0, 256);
        push_op(ACT_WRITE, 0, 4096);
        push_op(ACT_WRITE, 9, 0);
        push_op(ACT_FILTER, 0, -256);
        push_op(ACT_FILTER, 0, 0);
        pressure_go = 1'b1;
      end
      target = counted_beats + PHASE_BEATS;
      while (counted_beats < target) begin
        if ($urandom_range(99) < 80) begin
          style = $urandom_range(2);
          for (int i = 0; i < ORDER_DEF; i++) push_op(ACT_WRITE, i, rand_coef(i, style));
          if ($urandom_range(2) == 0) push_op(ACT_CLEAR, $urandom_range(15), $urandom);
          repeat ($urandom_range(4, 30))
            push_op(ACT_FILTER, $urandom_range(15), rand_excitation());
        end else begin
          push_op(2'($urandom_range(3)), $urandom_range(15), $urandom);
        end
      end
      while (pending_beats.size() != 0 || in_valid || expected_samples.size() != 0)
        @(posedge clk);
    end

    repeat (30) @(posedge clk);
    $display("Ran %0d beats in four idling phases, %0d of them filter samples;",
             counted_beats, filters_queued);
    $display("checked %0d speech samples, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
